[hw/rtl/stdu8_pkg.sv]
// shared types and constants for the utf-16 to utf-8 text transcoder
// used by the front, queue, back and top level
package stdu8_pkg;

    // unscramble modes held in the decode_mode register
    typedef enum logic [1:0] {
        MODE_PLAIN    = 2'd0,
        MODE_XOR      = 2'd1,
        MODE_BITSWAP  = 2'd2,
        MODE_BYTESWAP = 2'd3
    } t_mode;

    // configuration register word indexes
    localparam logic REG_DECODE_MODE = 1'b0;
    localparam int   APB_ADDR_W      = 3;
    localparam int   APB_DATA_W      = 32;

    // code unit constants
    localparam logic [15:0] BOM_UNIT      = 16'hFEFF;
    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    // job queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // one unit worth of work: an optional flushed high surrogate and an optional main point
    typedef struct packed {
        logic        has_p0;
        logic [9:0]  p0;
        logic        has_p1;
        logic [20:0] p1;
        logic        last;
    } t_job;

    // head of the job queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

endpackage

[hw/rtl/stdu8_unit_if.sv]
// input channel carrying raw 16-bit code units
// no dependencies
interface stdu8_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

[hw/rtl/stdu8_byte_if.sv]
// output channel carrying utf-8 bytes with run and text end marks
// no dependencies
interface stdu8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] utf8_byte;
    logic       last_of_run;
    logic       end_of_text;

    modport source (output valid, output utf8_byte, output last_of_run,
                    output end_of_text, input ready);
    modport sink   (input valid, input utf8_byte, input last_of_run,
                    input end_of_text, output ready);
endinterface

[hw/rtl/stdu8_front.sv]
// front end: unscrambles each code unit, tracks bom and surrogate state,
// and pushes a job of up to two code points; depends on stdu8_pkg, stdu8_unit_if
module stdu8_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stdu8_pkg::t_mode     i_mode,
    stdu8_unit_if.sink           i_in,
    input  logic                 i_fifo_full,
    output logic                 o_push,
    output stdu8_pkg::t_job      o_job
);

    logic       r_at_start, n_at_start;
    logic       r_held, n_held;
    logic [9:0] r_hval, n_hval;
    logic [15:0] unit;
    logic       accept;
    logic       is_high;
    logic       is_low;
    logic       bom;

    // undo the storage scramble for the selected mode
    function automatic logic [15:0] unscramble(input logic [15:0] u,
                                               input stdu8_pkg::t_mode m);
        logic [15:0] r;
        r = u;
        case (m)
            stdu8_pkg::MODE_XOR: begin
                if (u >= 16'h0020) begin
                    r = u ^ {u[7:1], 8'h00, 1'b1};
                end
            end
            stdu8_pkg::MODE_BITSWAP: begin
                for (int k = 0; k < 8; k++) begin
                    r[2*k]   = u[2*k+1];
                    r[2*k+1] = u[2*k];
                end
            end
            stdu8_pkg::MODE_BYTESWAP: begin
                r = {u[7:0], u[15:8]};
            end
            default: begin
                r = u;
            end
        endcase
        return r;
    endfunction

    assign i_in.ready = !i_fifo_full;
    assign accept     = i_in.valid && i_in.ready;

    // classify the unit and build the job
    always_comb begin
        unit       = unscramble(i_in.code_unit, i_mode);
        is_high    = (unit[15:10] == stdu8_pkg::HIGH_SURR_TAG);
        is_low     = (unit[15:10] == stdu8_pkg::LOW_SURR_TAG);
        bom        = r_at_start && (unit == stdu8_pkg::BOM_UNIT);
        n_at_start = r_at_start;
        n_held     = r_held;
        n_hval     = r_hval;
        o_job      = '0;
        o_job.last = i_in.last_unit;
        if (accept) begin
            if (!bom) begin
                if (r_held && is_low) begin
                    o_job.has_p1 = 1'b1;
                    o_job.p1     = stdu8_pkg::SUPP_BASE + {1'b0, r_hval, unit[9:0]};
                    n_held       = 1'b0;
                end else begin
                    if (r_held) begin
                        o_job.has_p0 = 1'b1;
                        o_job.p0     = r_hval;
                        n_held       = 1'b0;
                    end
                    if (is_high && !i_in.last_unit) begin
                        n_held = 1'b1;
                        n_hval = unit[9:0];
                    end else begin
                        o_job.has_p1 = 1'b1;
                        o_job.p1     = {5'b0, unit};
                    end
                end
            end
            if (i_in.last_unit) begin
                n_held     = 1'b0;
                n_hval     = '0;
                n_at_start = 1'b1;
            end else begin
                n_at_start = 1'b0;
            end
        end
        o_push = accept && (o_job.has_p0 || o_job.has_p1);
    end

    // text state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_held     <= 1'b0;
            r_hval     <= '0;
        end else begin
            r_at_start <= n_at_start;
            r_held     <= n_held;
            r_hval     <= n_hval;
        end
    end

endmodule

[hw/rtl/stdu8_queue.sv]
// short job queue between the front and back ends
// depends on stdu8_pkg
module stdu8_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  stdu8_pkg::t_job    i_job,
    input  logic               i_pop,
    output logic               o_full,
    output stdu8_pkg::t_head   o_head
);

    localparam int AW = stdu8_pkg::FIFO_AW;

    stdu8_pkg::t_job r_mem [stdu8_pkg::FIFO_DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [AW:0]     r_count, n_count;
    logic            do_push;
    logic            do_pop;

    // pointer and occupancy update
    always_comb begin
        do_push  = i_push && !o_full;
        do_pop   = i_pop && o_head.valid;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(stdu8_pkg::FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(stdu8_pkg::FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    assign o_full       = (r_count == (AW+1)'(stdu8_pkg::FIFO_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // occupancy never exceeds depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(stdu8_pkg::FIFO_DEPTH))
        else $error("job queue occupancy above depth");

    // a lone push grows the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("job queue count did not follow push");

    // a lone pop shrinks the count by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("job queue count did not follow pop");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full job queue");

endmodule

[hw/rtl/stdu8_back.sv]
// back end: expands each job into utf-8 bytes, one per cycle while the receiver takes them, into an output register
// depends on stdu8_pkg, stdu8_byte_if
module stdu8_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stdu8_pkg::t_head   i_head,
    output logic               o_pop,
    stdu8_byte_if.source       o_out
);

    logic            r_busy, n_busy;
    logic            r_sel, n_sel;
    logic [1:0]      r_idx, n_idx;
    stdu8_pkg::t_job r_job, n_job;
    logic            r_o_valid, n_o_valid;
    logic [7:0]      r_o_byte, n_o_byte;
    logic            r_o_run, n_o_run;
    logic            r_o_eot, n_o_eot;
    logic [20:0]     cur_cp;
    logic [1:0]      last_idx;
    logic [7:0]      cur_byte;
    logic            point_done;
    logic            run_done;
    logic            fire;
    logic            need;

    // index of the final byte of a point's utf-8 sequence
    function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
        logic [1:0] r;
        if (cp[20:7] == '0) begin
            r = 2'd0;
        end else if (cp[20:11] == '0) begin
            r = 2'd1;
        end else if (cp[20:16] == '0) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    // one byte of a point's utf-8 sequence
    function automatic logic [7:0] utf8_pick(input logic [20:0] cp, input logic [1:0] li,
                                             input logic [1:0] idx);
        logic [7:0] r;
        logic [1:0] shift;
        shift = li - idx;
        if (idx == 2'd0) begin
            case (li)
                2'd0:    r = {1'b0, cp[6:0]};
                2'd1:    r = {3'b110, cp[10:6]};
                2'd2:    r = {4'b1110, cp[15:12]};
                default: r = {5'b11110, cp[20:18]};
            endcase
        end else begin
            case (shift)
                2'd0:    r = {2'b10, cp[5:0]};
                2'd1:    r = {2'b10, cp[11:6]};
                default: r = {2'b10, cp[17:12]};
            endcase
        end
        return r;
    endfunction

    // byte selection and sequencing
    always_comb begin
        cur_cp     = r_sel ? r_job.p1 : {5'b0, stdu8_pkg::HIGH_SURR_TAG, r_job.p0};
        last_idx   = utf8_last_idx(cur_cp);
        cur_byte   = utf8_pick(cur_cp, last_idx, r_idx);
        point_done = (r_idx == last_idx);
        run_done   = point_done && (r_sel || !r_job.has_p1);
        fire       = r_busy && (!r_o_valid || o_out.ready);
        need       = !r_busy || (fire && run_done);
        o_pop      = need && i_head.valid;

        n_o_valid = r_o_valid;
        n_o_byte  = r_o_byte;
        n_o_run   = r_o_run;
        n_o_eot   = r_o_eot;
        if (fire) begin
            n_o_valid = 1'b1;
            n_o_byte  = cur_byte;
            n_o_run   = run_done;
            n_o_eot   = run_done && r_job.last;
        end else if (o_out.ready) begin
            n_o_valid = 1'b0;
        end

        n_busy = r_busy;
        n_sel  = r_sel;
        n_idx  = r_idx;
        n_job  = r_job;
        if (o_pop) begin
            n_job  = i_head.job;
            n_busy = 1'b1;
            n_sel  = !i_head.job.has_p0;
            n_idx  = 2'd0;
        end else if (need) begin
            n_busy = 1'b0;
        end else if (fire) begin
            if (point_done) begin
                n_sel = 1'b1;
                n_idx = 2'd0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sel    <= n_sel;
        r_idx    <= n_idx;
        r_job    <= n_job;
        r_o_byte <= n_o_byte;
        r_o_run  <= n_o_run;
        r_o_eot  <= n_o_eot;
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.utf8_byte   = r_o_byte;
    assign o_out.last_of_run = r_o_run;
    assign o_out.end_of_text = r_o_eot;

endmodule

[hw/rtl/scenario_text_decrypt_to_utf8_top.sv]
// top level of the utf-16 to utf-8 text transcoder with apb mode register
// depends on stdu8_pkg, stdu8_unit_if, stdu8_byte_if, stdu8_front, stdu8_queue, stdu8_back
// path: the first byte of a unit passes the job queue, the back end's job register and its output register
// throughput: one code unit per cycle into a four-job queue while it is not full; one utf-8 byte
// per cycle out of the back end's byte sequencer while the receiver is ready; a unit yields 0 to 6 bytes
// reset: synchronous active low; clears the mode to plain, surrogate state and queue
module scenario_text_decrypt_to_utf8_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    stdu8_unit_if.sink                          i_in,
    stdu8_byte_if.source                        o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stdu8_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [stdu8_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [stdu8_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    stdu8_pkg::t_mode r_decode_mode;
    logic             cfg_write;
    logic             push;
    logic             pop;
    logic             fifo_full;
    stdu8_pkg::t_job  push_job;
    stdu8_pkg::t_head head;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == stdu8_pkg::REG_DECODE_MODE);

    always_comb begin
        if (paddr[2] == stdu8_pkg::REG_DECODE_MODE) begin
            prdata = {{(stdu8_pkg::APB_DATA_W-2){1'b0}}, r_decode_mode};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= stdu8_pkg::MODE_PLAIN;
        end else if (cfg_write) begin
            r_decode_mode <= stdu8_pkg::t_mode'(pwdata[1:0]);
        end
    end

    // front end
    stdu8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_decode_mode),
        .i_in        (i_in),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    // job queue
    stdu8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_head  (head)
    );

    // back end
    stdu8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[test/tb_scenario_text_decrypt_to_utf8_top.sv]
// self-checking testbench for the utf-16 to utf-8 text transcoder top level
// depends on stdu8_pkg, stdu8_unit_if, stdu8_byte_if and the transcoder rtl
// directed table first, then random texts checked against a built-in transcode model
`timescale 1ns / 100ps

module tb_scenario_text_decrypt_to_utf8_top;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES   = 10;
    localparam int NUM_PHASES      = 7;
    localparam int UNITS_PER_PHASE = 62;
    localparam int HOLD_PHASE      = 0;
    localparam int STEADY_PHASE    = 2;
    localparam int PAUSE_PHASE     = 3;
    localparam logic [stdu8_pkg::APB_ADDR_W-1:0] MODE_ADDR =
        {stdu8_pkg::REG_DECODE_MODE, 2'b00};

    // one row of the directed table; utf8 holds the bytes with the final byte lowest
    typedef struct packed {
        stdu8_pkg::t_mode mode;
        logic [15:0]      cu;
        logic             last;
        logic             typed;
        logic [2:0]       n;
        logic [47:0]      utf8;
    } t_dir_row;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       last_of_run;
        logic       end_of_text;
    } t_utf8_out;

    localparam int NUM_DIR = 27;
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{stdu8_pkg::MODE_PLAIN,    16'h0000, 1'b1, 1'b1, 3'd1, 48'h00},
        '{stdu8_pkg::MODE_PLAIN,    16'h007F, 1'b1, 1'b1, 3'd1, 48'h7F},
        '{stdu8_pkg::MODE_PLAIN,    16'h0080, 1'b1, 1'b1, 3'd2, 48'hC280},
        '{stdu8_pkg::MODE_PLAIN,    16'h07FF, 1'b1, 1'b1, 3'd2, 48'hDFBF},
        '{stdu8_pkg::MODE_PLAIN,    16'h0800, 1'b1, 1'b1, 3'd3, 48'hE0A080},
        '{stdu8_pkg::MODE_PLAIN,    16'hFFFF, 1'b1, 1'b1, 3'd3, 48'hEFBFBF},
        // leading mark that also ends the text: nothing comes out
        '{stdu8_pkg::MODE_PLAIN,    16'hFEFF, 1'b1, 1'b1, 3'd0, 48'h0},
        '{stdu8_pkg::MODE_PLAIN,    16'hFEFF, 1'b0, 1'b1, 3'd0, 48'h0},
        '{stdu8_pkg::MODE_PLAIN,    16'h0041, 1'b1, 1'b1, 3'd1, 48'h41},
        // mark inside a text is an ordinary character
        '{stdu8_pkg::MODE_PLAIN,    16'h0042, 1'b0, 1'b1, 3'd1, 48'h42},
        '{stdu8_pkg::MODE_PLAIN,    16'hFEFF, 1'b1, 1'b1, 3'd3, 48'hEFBBBF},
        '{stdu8_pkg::MODE_PLAIN,    16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
        '{stdu8_pkg::MODE_PLAIN,    16'hDC00, 1'b1, 1'b1, 3'd4, 48'hF0908080},
        '{stdu8_pkg::MODE_PLAIN,    16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0},
        '{stdu8_pkg::MODE_PLAIN,    16'hDFFF, 1'b1, 1'b1, 3'd4, 48'hF48FBFBF},
        // held high surrogate flushed by a plain character
        '{stdu8_pkg::MODE_PLAIN,    16'hD801, 1'b0, 1'b1, 3'd0, 48'h0},
        '{stdu8_pkg::MODE_PLAIN,    16'h0041, 1'b1, 1'b1, 3'd4, 48'hEDA08141},
        // held high flushed by a high surrogate that ends the text
        '{stdu8_pkg::MODE_PLAIN,    16'hD802, 1'b0, 1'b1, 3'd0, 48'h0},
        '{stdu8_pkg::MODE_PLAIN,    16'hD803, 1'b1, 1'b1, 3'd6, 48'hEDA082EDA083},
        '{stdu8_pkg::MODE_PLAIN,    16'hDC05, 1'b1, 1'b1, 3'd3, 48'hEDB085},
        '{stdu8_pkg::MODE_PLAIN,    16'hDBFF, 1'b1, 1'b1, 3'd3, 48'hEDAFBF},
        '{stdu8_pkg::MODE_XOR,      16'h001F, 1'b1, 1'b0, 3'd0, 48'h0},
        '{stdu8_pkg::MODE_XOR,      16'h0020, 1'b1, 1'b0, 3'd0, 48'h0},
        '{stdu8_pkg::MODE_XOR,      16'hFFFF, 1'b1, 1'b0, 3'd0, 48'h0},
        '{stdu8_pkg::MODE_BITSWAP,  16'hAAAA, 1'b1, 1'b0, 3'd0, 48'h0},
        // big-endian mark dropped, then a swapped ascii letter
        '{stdu8_pkg::MODE_BYTESWAP, 16'hFFFE, 1'b0, 1'b1, 3'd0, 48'h0},
        '{stdu8_pkg::MODE_BYTESWAP, 16'h4100, 1'b1, 1'b1, 3'd1, 48'h41}
    };

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [stdu8_pkg::APB_ADDR_W-1:0] paddr;
    logic [stdu8_pkg::APB_DATA_W-1:0] pwdata;
    logic [stdu8_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    stdu8_unit_if u_in ();
    stdu8_byte_if u_out ();

    scenario_text_decrypt_to_utf8_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // transcoder model state
    stdu8_pkg::t_mode mode_shadow;
    logic [9:0]       held_high;
    logic             high_pending;
    logic             text_start;

    t_utf8_out  utf8_expected [$];
    logic [7:0] unit_bytes [$];
    int         error_count;

    // traffic shaping knobs; the rx ones are shared with the receiver process
    bit tx_gaps;
    bit rx_stalls;
    bit rx_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] unscramble_unit(input logic [15:0] u);
        logic [15:0] r;
        r = u;
        case (mode_shadow)
            stdu8_pkg::MODE_XOR: begin
                if (u >= 16'h0020) r = u ^ {u[7:1], 1'b0, 8'h01};
            end
            stdu8_pkg::MODE_BITSWAP: begin
                r = ((u & 16'hAAAA) >> 1) | ((u & 16'h5555) << 1);
            end
            stdu8_pkg::MODE_BYTESWAP: begin
                r = {u[7:0], u[15:8]};
            end
            default: begin
                r = u;
            end
        endcase
        return r;
    endfunction

    // stored unit that unscrambles to the wanted one under the current mode
    function automatic logic [15:0] raw_unit_for(input logic [15:0] t);
        logic [15:0] r;
        if (mode_shadow == stdu8_pkg::MODE_XOR) begin
            if (t < 16'h0020) begin
                r = t;
            end else begin
                r[7:0]  = t[7:0] ^ 8'h01;
                r[15:8] = t[15:8] ^ {r[7:1], 1'b0};
            end
        end else begin
            // bit swap and byte swap undo themselves
            r = unscramble_unit(t);
        end
        return r;
    endfunction

    // append one predicted byte of the current unit
    function automatic void add_unit_byte(input logic [7:0] b);
        unit_bytes = {unit_bytes, b};
    endfunction

    function automatic void encode_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_unit_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            add_unit_byte({3'b110, cp[10:6]});
            add_unit_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            add_unit_byte({4'b1110, cp[15:12]});
            add_unit_byte({2'b10, cp[11:6]});
            add_unit_byte({2'b10, cp[5:0]});
        end else begin
            add_unit_byte({5'b11110, cp[20:18]});
            add_unit_byte({2'b10, cp[17:12]});
            add_unit_byte({2'b10, cp[11:6]});
            add_unit_byte({2'b10, cp[5:0]});
        end
    endfunction

    // expected bytes of one accepted code unit, appended to utf8_expected
    function automatic void transcode_unit(input logic [15:0] raw, input logic last_u);
        logic [15:0] u;
        logic        first;
        logic        is_hi;
        logic        is_lo;
        t_utf8_out   rec;
        u = unscramble_unit(raw);
        first = text_start;
        text_start = 1'b0;
        unit_bytes.delete();
        if (!(first && u == stdu8_pkg::BOM_UNIT)) begin
            is_hi = (u[15:10] == stdu8_pkg::HIGH_SURR_TAG);
            is_lo = (u[15:10] == stdu8_pkg::LOW_SURR_TAG);
            if (high_pending && is_lo) begin
                high_pending = 1'b0;
                encode_point(21'(stdu8_pkg::SUPP_BASE + {held_high, u[9:0]}));
            end else begin
                if (high_pending) begin
                    encode_point({5'b0, stdu8_pkg::HIGH_SURR_TAG, held_high});
                    high_pending = 1'b0;
                end
                if (is_hi && !last_u) begin
                    held_high = u[9:0];
                    high_pending = 1'b1;
                end else begin
                    encode_point({5'b0, u});
                end
            end
        end
        foreach (unit_bytes[k]) begin
            rec.utf8_byte   = unit_bytes[k];
            rec.last_of_run = (k == unit_bytes.size() - 1);
            rec.end_of_text = rec.last_of_run && last_u;
            utf8_expected = {utf8_expected, rec};
        end
        if (last_u) begin
            high_pending = 1'b0;
            held_high = '0;
            text_start = 1'b1;
        end
    endfunction

    task automatic apb_write(input logic [stdu8_pkg::APB_ADDR_W-1:0] addr,
                             input logic [stdu8_pkg::APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [stdu8_pkg::APB_ADDR_W-1:0] addr);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one code unit, predict it once the transaction completes
    task automatic send_unit(input logic [15:0] raw, input logic last_u);
        u_in.valid <= 1'b1;
        u_in.code_unit <= raw;
        u_in.last_unit <= last_u;
        do @(posedge i_clk); while (!u_in.ready);
        transcode_unit(raw, last_u);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            u_in.valid <= 1'b0;
            u_in.code_unit <= 16'($urandom);
            repeat (gap_len()) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every expected byte is out and the pipe is quiet
    task automatic wait_drained();
        u_in.valid <= 1'b0;
        do @(posedge i_clk); while (utf8_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one random text, mostly well formed, with some raw noise units
    task automatic send_random_text(inout int sent);
        logic [15:0] units [$];
        int          len;
        int          r;
        len = $urandom_range(1, 8);
        if ($urandom_range(0, 4) == 0) units = {units, raw_unit_for(stdu8_pkg::BOM_UNIT)};
        while (units.size() < len) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                units = {units, raw_unit_for(16'($urandom_range(0, 'h7F)))};
            end else if (r < 40) begin
                units = {units, raw_unit_for(16'($urandom_range('h80, 'h7FF)))};
            end else if (r < 55) begin
                if ($urandom_range(0, 1) == 0)
                    units = {units, raw_unit_for(16'($urandom_range('h800, 'hD7FF)))};
                else
                    units = {units, raw_unit_for(16'($urandom_range('hE000, 'hFFFF)))};
            end else if (r < 72) begin
                units = {units, raw_unit_for(16'($urandom_range('hD800, 'hDBFF)))};
                units = {units, raw_unit_for(16'($urandom_range('hDC00, 'hDFFF)))};
            end else if (r < 80) begin
                units = {units, raw_unit_for(16'($urandom_range('hD800, 'hDBFF)))};
            end else if (r < 86) begin
                units = {units, raw_unit_for(16'($urandom_range('hDC00, 'hDFFF)))};
            end else begin
                units = {units, 16'($urandom)};
            end
        end
        foreach (units[k]) begin
            send_unit(units[k], k == units.size() - 1);
        end
        sent += units.size();
    endtask

    // receiver: random stalls, a long hold-off on request, or always ready
    initial begin
        u_out.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                u_out.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (!rx_stalls) begin
                u_out.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                u_out.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                u_out.ready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end
        end
    end

    // output byte check against the oldest expectation
    always @(posedge i_clk) begin : out_check
        t_utf8_out want;
        if (i_rst_n && u_out.valid && u_out.ready) begin
            if (utf8_expected.size() == 0) begin
                $error("unexpected transaction: utf8_byte %h", u_out.utf8_byte);
                error_count++;
            end else begin
                want = utf8_expected.pop_front();
                if (u_out.utf8_byte !== want.utf8_byte) begin
                    $error("utf8_byte: expected %h, got %h", want.utf8_byte, u_out.utf8_byte);
                    error_count++;
                end
                if (u_out.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %b, got %b", want.last_of_run, u_out.last_of_run);
                    error_count++;
                end
                if (u_out.end_of_text !== want.end_of_text) begin
                    $error("end_of_text: expected %b, got %b", want.end_of_text, u_out.end_of_text);
                    error_count++;
                end
            end
        end
    end

    // register port: track writes, check reads
    always @(posedge i_clk) begin
        if (i_rst_n && psel && penable && pready) begin
            if (pwrite) begin
                if (paddr == MODE_ADDR) mode_shadow = stdu8_pkg::t_mode'(pwdata[1:0]);
            end else if (prdata !== {{(stdu8_pkg::APB_DATA_W-2){1'b0}}, mode_shadow}) begin
                $error("decode_mode: expected %h, got %h", mode_shadow, prdata);
                error_count++;
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((u_in.valid && u_in.ready) || (u_out.valid && u_out.ready) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        stdu8_pkg::t_mode dir_mode;
        stdu8_pkg::t_mode phase_mode;
        int               sent;
        bit               paused;
        int               n;

        i_rst_n <= 1'b0;
        u_in.valid <= 1'b0;
        u_in.code_unit <= '0;
        u_in.last_unit <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        error_count = 0;
        mode_shadow = stdu8_pkg::MODE_PLAIN;
        held_high = '0;
        high_pending = 1'b0;
        text_start = 1'b1;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        rx_hold_req = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register reads back its reset value
        apb_read(MODE_ADDR);

        // directed table
        dir_mode = stdu8_pkg::MODE_PLAIN;
        for (int i = 0; i < NUM_DIR; i++) begin
            if (DIR_ROWS[i].mode != dir_mode) begin
                wait_drained();
                dir_mode = DIR_ROWS[i].mode;
                apb_write(MODE_ADDR, {{(stdu8_pkg::APB_DATA_W-2){1'b0}}, dir_mode});
            end
            send_unit(DIR_ROWS[i].cu, DIR_ROWS[i].last);
            if (DIR_ROWS[i].typed) begin
                n = DIR_ROWS[i].n;
                if (unit_bytes.size() != n) begin
                    $error("row %0d byte count: expected %0d, got %0d", i, n, unit_bytes.size());
                    error_count++;
                end else begin
                    for (int k = 0; k < n; k++) begin
                        if (unit_bytes[k] !== DIR_ROWS[i].utf8[8*(n-1-k) +: 8]) begin
                            $error("row %0d utf8_byte: expected %h, got %h", i,
                                   DIR_ROWS[i].utf8[8*(n-1-k) +: 8], unit_bytes[k]);
                            error_count++;
                        end
                    end
                end
            end
        end

        // random phases; each sets a mode and a traffic pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: phase_mode = stdu8_pkg::MODE_BYTESWAP;
                1: phase_mode = stdu8_pkg::MODE_XOR;
                2: phase_mode = stdu8_pkg::MODE_BITSWAP;
                3: phase_mode = stdu8_pkg::MODE_PLAIN;
                default: phase_mode = stdu8_pkg::t_mode'($urandom_range(0, 3));
            endcase
            apb_write(MODE_ADDR, {{(stdu8_pkg::APB_DATA_W-2){1'b0}}, phase_mode});
            apb_read(MODE_ADDR);
            tx_gaps = (ph != HOLD_PHASE) && (ph != STEADY_PHASE);
            rx_stalls = (ph != STEADY_PHASE);
            rx_hold_req = (ph == HOLD_PHASE);
            sent = 0;
            paused = 1'b0;
            while (sent < UNITS_PER_PHASE) begin
                send_random_text(sent);
                if (ph == PAUSE_PHASE && !paused && sent >= UNITS_PER_PHASE / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (utf8_expected.size() != 0) begin
            $error("%0d expected utf8 bytes never arrived", utf8_expected.size());
            error_count++;
        end
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
